@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Queue depth, field widths, request and status codes, the cell command
// struct and the ordering compare.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PH_W     = $clog2(CAPACITY);

	localparam logic REQ_INS = 1'b0;
	localparam logic REQ_REM = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2,
		OP_SORT = 2'd3
	} op_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		op_t              op;
		logic             phase;
		logic             mode;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

	// True when a must stand strictly ahead of b in the given order
	function automatic logic goes_before(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b, input logic mode);
		logic lt;
		logic gt;
		lt = ($signed(a) < $signed(b));
		gt = ($signed(a) > $signed(b));
		return mode ? lt : gt;
	endfunction

endpackage

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry and picks its next value from itself, its neighbors or the
// new word: shift-in on insert, shift-down on remove, compare-swap on sort.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] idx,
	input  logic [VAL_W-1:0] left_q,
	input  logic             left_m,
	input  logic [VAL_W-1:0] right_q,
	input  logic             right_lt,
	output logic [VAL_W-1:0] q,
	output logic             m,
	output logic             lt,
	output logic [VAL_W-1:0] d
);

	logic [VAL_W-1:0] entry_q;
	logic             own_valid;
	logic             right_valid;
	logic             is_left;

	assign q           = entry_q;
	assign own_valid   = (idx < ctrl.count);
	assign right_valid = (({1'b0, idx} + 1'b1) < {1'b0, ctrl.count});
	assign is_left     = (idx[0] == ctrl.phase);

	// At or past the insertion point
	assign m  = !own_valid || goes_before(ctrl.value, entry_q, ctrl.mode);
	assign lt = goes_before(entry_q, left_q, ctrl.mode);

	always_comb begin
		d = entry_q;
		case (ctrl.op)
			OP_INS: begin
				if (m) begin
					d = left_m ? left_q : ctrl.value;
				end
			end
			OP_REM: begin
				d = right_q;
			end
			OP_SORT: begin
				if (is_left && right_valid && right_lt) begin
					d = right_q;
				end else if (!is_left && own_valid && lt && (idx != '0)) begin
					d = left_q;
				end
			end
			default: begin
				d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= d;
	end

endmodule

@@ hw/rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer and result register of the sorted priority queue
// Decodes requests, keeps the count and the order the row is sorted in, runs
// the re-sort passes after a mode change and registers the result word.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] removed_value,
	output logic [VAL_W-1:0] front_value,
	output logic [CNT_W-1:0] entry_count,
	output logic             is_empty,
	output logic [1:0]       status,
	input  logic [VAL_W-1:0] head_q,
	input  logic [VAL_W-1:0] head_d,
	output cell_ctrl_t       ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SORT = 3'b010,
		ST_INS  = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	logic             min_mode_q;
	logic             sorted_mode_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [PH_W-1:0]  phase_q;
	logic [VAL_W-1:0] pend_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] removed_q;
	logic [VAL_W-1:0] front_q;
	logic [CNT_W-1:0] entry_count_q;
	logic             is_empty_q;
	logic [1:0]       status_q;

	logic             accept;
	logic             full;
	logic             need_sort;
	logic             res_load;
	logic [1:0]       res_status;
	op_t              op;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign need_sort = (sorted_mode_q != min_mode_q) && (count_q > CNT_W'(1));

	always_comb begin
		op         = OP_HOLD;
		state_nxt  = state_q;
		res_load   = 1'b0;
		res_status = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_INS) begin
						if (full) begin
							res_load   = 1'b1;
							res_status = STAT_FULL;
						end else if (need_sort) begin
							state_nxt = ST_SORT;
						end else begin
							op       = OP_INS;
							res_load = 1'b1;
						end
					end else begin
						res_load = 1'b1;
						if (count_q == '0) begin
							res_status = STAT_EMPTY;
						end else begin
							op = OP_REM;
						end
					end
				end
			end
			ST_SORT: begin
				op = OP_SORT;
				if (phase_q == PH_W'(CAPACITY - 1)) begin
					state_nxt = ST_INS;
				end
			end
			ST_INS: begin
				op        = OP_INS;
				res_load  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		case (op)
			OP_INS:  count_nxt = count_q + 1'b1;
			OP_REM:  count_nxt = count_q - 1'b1;
			default: count_nxt = count_q;
		endcase
	end

	assign ctrl.op    = op;
	assign ctrl.phase = phase_q[0];
	assign ctrl.mode  = min_mode_q;
	assign ctrl.value = (state_q == ST_INS) ? pend_q : value;
	assign ctrl.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_mode_q    <= 1'b1;
			sorted_mode_q <= 1'b1;
			count_q       <= '0;
			phase_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (cfg_we) begin
				min_mode_q <= cfg_wdata;
			end
			if (op == OP_INS) begin
				sorted_mode_q <= min_mode_q;
			end
			phase_q <= (state_q == ST_SORT) ? phase_q + 1'b1 : '0;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= value;
		end
		if (res_load) begin
			removed_q     <= (op == OP_REM) ? head_q : '0;
			front_q       <= (count_nxt == '0) ? '0 : head_d;
			entry_count_q <= count_nxt;
			is_empty_q    <= (count_nxt == '0);
			status_q      <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign front_value   = front_q;
	assign entry_count   = entry_count_q;
	assign is_empty      = is_empty_q;
	assign status        = status_q;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: min/max priority queue on a row of sorted cells
// Entries stay sorted across a row of cells; insert and remove act on every
// cell at once, and a mode change is repaired by odd-even compare-swap passes.
// ----------------------------------------------------------------------------
//  channel   signals                                   dir   handshake
//  input     req_type, value                           in    in_valid / in_ready
//  result    removed_value, front_value, entry_count,  out   out_valid / out_ready
//            is_empty, status
//  config    cfg_wdata (min_mode)                      in    cfg_we, no wait
//
//  An insert or remove acts on the cell row as it is accepted; its result is
//  registered and shows the next cycle. in_ready is high when idle and the
//  result register is free or being taken, so one word per cycle is taken
//  while out_ready stays high and no re-sort runs; a stalled result holds
//  off the input. The first insert after a change of min_mode with two or
//  more entries stored first runs odd-even passes, then the insert itself.
//  Reset clears the count and the control state; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] removed_value,
	output logic [VAL_W-1:0] front_value,
	output logic [CNT_W-1:0] entry_count,
	output logic             is_empty,
	output logic [1:0]       status
);

	cell_ctrl_t       ctrl;
	logic [VAL_W-1:0] q_w     [CAPACITY];
	logic [VAL_W-1:0] d_w     [CAPACITY];
	logic             m_w     [CAPACITY];
	logic             lt_w    [CAPACITY];
	logic [VAL_W-1:0] left_q  [CAPACITY];
	logic             left_m  [CAPACITY];
	logic [VAL_W-1:0] right_q [CAPACITY];
	logic             right_lt[CAPACITY];

	spq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.front_value   (front_value),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.status        (status),
		.head_q        (q_w[0]),
		.head_d        (d_w[0]),
		.ctrl          (ctrl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_q[i] = '0;
			assign left_m[i] = 1'b0;
		end else begin : g_mid
			assign left_q[i] = q_w[i-1];
			assign left_m[i] = m_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_q[i]  = q_w[i];
			assign right_lt[i] = 1'b0;
		end else begin : g_inner
			assign right_q[i]  = q_w[i+1];
			assign right_lt[i] = lt_w[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.idx      (CNT_W'(i)),
			.left_q   (left_q[i]),
			.left_m   (left_m[i]),
			.right_q  (right_q[i]),
			.right_lt (right_lt[i]),
			.q        (q_w[i]),
			.m        (m_w[i]),
			.lt       (lt_w[i]),
			.d        (d_w[i])
		);
	end

endmodule

@@ hw/rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the result channel for consistent counts, flags and stalls.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [VAL_W-1:0] removed_value,
	input logic [VAL_W-1:0] front_value,
	input logic [CNT_W-1:0] entry_count,
	input logic             is_empty,
	input logic [1:0]       status
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)) &&
			(!is_empty || front_value == '0))
		else $error("empty flag inconsistent with count or front");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> is_empty && removed_value == '0)
		else $error("failed remove reported a value or entries");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count == CNT_W'(CAPACITY) &&
			removed_value == '0)
		else $error("dropped insert on a queue that was not full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_value) &&
			$stable(entry_count))
		else $error("result word changed while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

@@ tb/tb_sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives insert and remove words through the valid/ready input, predicts each
// result with a behavioral sorted list, and checks every result word field by
// field. Runs directed corner cases, then random phases with min_mode changes
// on a non-empty queue, sender and receiver idling, and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
	import spq_pkg::*;

	typedef struct packed {
		logic             req;
		logic [VAL_W-1:0] val;
	} pq_request_t;

	typedef struct packed {
		logic [VAL_W-1:0] removed;
		logic [VAL_W-1:0] front;
		logic [CNT_W-1:0] count;
		logic             empty;
		logic [1:0]       status;
	} pq_result_t;

	localparam int HOLD_CYCLES = 120;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_wdata = 1'b1;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic             req_type  = REQ_INS;
	logic [VAL_W-1:0] value     = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [VAL_W-1:0] removed_value;
	logic [VAL_W-1:0] front_value;
	logic [CNT_W-1:0] entry_count;
	logic             is_empty;
	logic [1:0]       status;

	// behavioral copy of the queue
	logic signed [VAL_W-1:0] model_list [CAPACITY];
	int                      model_count    = 0;
	logic                    model_min_mode = 1'b1;

	pq_request_t pending_words [$];
	pq_result_t  expected_results [$];
	pq_request_t offered_word;
	pq_result_t  want_result;
	pq_result_t  got_result;

	int  sender_idle_pct = 0;
	int  receiver_stall_pct = 0;
	logic receiver_hold = 1'b0;
	bit  pressure_go = 1'b0;
	int  plan_count = 0;
	bit  filling = 1'b1;

	int fail_count = 0;
	int results_checked = 0;
	int n_insert = 0;
	int n_remove = 0;
	int n_full_drop = 0;
	int n_empty_remove = 0;
	int n_mode_writes = 0;

	sorted_priority_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.front_value   (front_value),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still expected", expected_results.size());
		$display("sorted_priority_queue verification failed");
		$finish;
	end

	// Apply one request to the sorted list and return the result word it gives
	function automatic pq_result_t apply_request(input logic req, input logic [VAL_W-1:0] val);
		pq_result_t              r;
		logic signed [VAL_W-1:0] key;
		int                      i;
		int                      j;
		r = '0;
		r.status = STAT_OK;
		if (req == REQ_INS) begin
			n_insert++;
			if (model_count >= CAPACITY) begin
				r.status = STAT_FULL;
				n_full_drop++;
			end else begin
				model_list[model_count] = val;
				model_count++;
				// full re-sort: repairs a list left in the old order by a mode change
				for (i = 1; i < model_count; i++) begin
					key = model_list[i];
					j = i;
					while (j > 0 && (model_min_mode ? key < model_list[j-1]
							: key > model_list[j-1])) begin
						model_list[j] = model_list[j-1];
						j--;
					end
					model_list[j] = key;
				end
			end
		end else begin
			n_remove++;
			if (model_count == 0) begin
				r.status = STAT_EMPTY;
				n_empty_remove++;
			end else begin
				r.removed = model_list[0];
				for (i = 1; i < model_count; i++)
					model_list[i-1] = model_list[i];
				model_count--;
			end
		end
		r.front = (model_count > 0) ? model_list[0] : '0;
		r.count = model_count[CNT_W-1:0];
		r.empty = (model_count == 0);
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = $urandom_range(16) - 8;  // narrow range to force ties
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Sender: offer the next pending word, hold it until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					apply_request(req_type, value));
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					offered_word = pending_words.pop_front();
					in_valid <= 1'b1;
					req_type <= offered_word.req;
					value    <= offered_word.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus the long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
	end

	initial begin
		wait (pressure_go);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_result = '{removed_value, front_value, entry_count, is_empty, status};
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: removed %h front %h count %0d empty %b status %0d",
						removed_value, front_value, entry_count, is_empty, status);
			end else begin
				want_result = expected_results.pop_front();
				results_checked++;
				if (got_result.removed !== want_result.removed
						|| got_result.front !== want_result.front
						|| got_result.count !== want_result.count
						|| got_result.empty !== want_result.empty
						|| got_result.status !== want_result.status) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch on result %0d:", results_checked);
						$display("  expected removed %h front %h count %0d empty %b status %0d",
							want_result.removed, want_result.front, want_result.count,
							want_result.empty, want_result.status);
						$display("  actual   removed %h front %h count %0d empty %b status %0d",
							got_result.removed, got_result.front, got_result.count,
							got_result.empty, got_result.status);
					end
				end
			end
		end
	end

	task automatic queue_word(input logic req, input logic [VAL_W-1:0] val);
		pending_words.insert(pending_words.size(), pq_request_t'{req, val});
		if (req == REQ_INS && plan_count < CAPACITY)
			plan_count++;
		else if (req == REQ_REM && plan_count > 0)
			plan_count--;
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		// a mode repair pass may still be running
		repeat (CAPACITY + 4) @(negedge clk);
	endtask

	task automatic write_min_mode(input logic mode);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_min_mode = mode;
		n_mode_writes++;
	endtask

	// Mostly fill-then-drain runs so both the full and the empty boundary get hit
	task automatic queue_random_words(input int n);
		int   k;
		logic req;
		for (k = 0; k < n; k++) begin
			if (filling)
				req = ($urandom_range(99) < 80) ? REQ_INS : REQ_REM;
			else
				req = ($urandom_range(99) < 80) ? REQ_REM : REQ_INS;
			if ($urandom_range(19) == 0)
				req = ~req;
			queue_word(req, pick_value());
			if (plan_count == CAPACITY && $urandom_range(2) == 0)
				filling = 1'b0;
			if (plan_count == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
			if ($urandom_range(29) == 0)
				filling = ~filling;
		end
	endtask

	task automatic run_phase(input logic mode, input int idle_pct, input int stall_pct,
			input int n, input bit pressure);
		wait_idle();
		write_min_mode(mode);
		@(negedge clk);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		if (pressure)
			pressure_go = 1'b1;
		queue_random_words(n);
	endtask

	initial begin
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty remove, extremes, ties, fill to full, drop when full
		write_min_mode(1'b1);
		@(negedge clk);
		queue_word(REQ_REM, 32'h1234_5678);
		queue_word(REQ_INS, 32'h7FFF_FFFF);
		queue_word(REQ_INS, 32'h8000_0000);
		queue_word(REQ_INS, 32'h0000_0000);
		queue_word(REQ_INS, 32'hFFFF_FFFF);
		queue_word(REQ_INS, 32'h0000_0001);
		queue_word(REQ_INS, 32'hFFFF_FFFF);
		for (k = 0; k < 9; k++)
			queue_word(REQ_INS, pick_value());
		queue_word(REQ_INS, 32'h5555_AAAA);
		queue_word(REQ_REM, 32'h0);
		queue_word(REQ_INS, 32'hAAAA_5555);
		queue_word(REQ_INS, 32'h0F0F_0F0F);

		// flip to max order with a full queue: front stays, next insert re-sorts
		wait_idle();
		write_min_mode(1'b0);
		@(negedge clk);
		queue_word(REQ_REM, 32'h0);
		queue_word(REQ_REM, 32'h0);
		queue_word(REQ_INS, 32'h0000_0005);
		queue_word(REQ_REM, 32'h0);
		queue_word(REQ_INS, 32'h7FFF_FFFF);
		queue_word(REQ_REM, 32'h0);

		run_phase(1'b1, 0, 0, 100, 1'b0);
		run_phase(1'b0, 86, 0, 90, 1'b0);
		run_phase(1'b1, 0, 86, 90, 1'b0);
		run_phase(1'b0, 15, 15, 100, 1'b0);
		run_phase(1'b1, 0, 0, 60, 1'b1);
		run_phase(1'b0, 0, 0, 100, 1'b0);
		run_phase(1'b1, 15, 15, 100, 1'b0);
		run_phase(1'b0, 0, 0, 80, 1'b0);

		wait_idle();
		$display("checked %0d results: %0d inserts (%0d dropped full), %0d removes (%0d on empty)",
			results_checked, n_insert, n_full_drop, n_remove, n_empty_remove);
		$display("%0d min_mode writes, idling and a %0d-cycle output stall covered",
			n_mode_writes, HOLD_CYCLES);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("sorted_priority_queue verification clean");
		else
			$display("sorted_priority_queue verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
